// ----- src/bhpq_pkg.sv -----
// ============================================================================
// bhpq_pkg
// Shared types, constants and helpers for the binary heap priority queue:
// heap geometry, level memory sizing, transfer structs and the order compare.
// ============================================================================
package bhpq_pkg;

    // heap geometry
    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int NUM_LEVELS = $clog2(CAPACITY + 1);
    localparam int IDX_WIDTH  = NUM_LEVELS;
    localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);
    localparam int LVL_WIDTH  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // stream field widths
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 11;
    localparam int MDATA_WIDTH = 80;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    // two sibling entries, slot 1 holds the odd index
    typedef logic [1:0][DATA_WIDTH-1:0]   pair_t;
    typedef logic [IDX_WIDTH-1:0]         idx_t;
    typedef logic [CNT_WIDTH-1:0]         cnt_t;
    typedef logic [LVL_WIDTH-1:0]         lvl_t;

    // sift token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  up;
        idx_t  idx;
        data_t val;
        pair_t held;
    } tok_t;

    typedef struct packed {
        logic  en;
        idx_t  idx;
        pair_t data;
    } wreq_t;

    typedef struct packed {
        logic en;
        idx_t idx;
    } rreq_t;

    // true if a belongs above b; mode 1 is min order, 0 is max order
    function automatic logic ranks_above(input logic mode, input data_t a, input data_t b);
        return mode ? (a < b) : (a > b);
    endfunction

    // number of sibling pairs stored at one heap level
    function automatic int level_depth(input int k);
        int lo;
        int hi;
        lo = 1 << k;
        hi = (1 << (k + 1)) - 1;
        if (hi > CAPACITY) hi = CAPACITY;
        return (hi >> 1) - (lo >> 1) + 1;
    endfunction

    function automatic int ram_addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // level of a 1-based heap index (position of its top set bit)
    function automatic lvl_t level_of(input idx_t i);
        lvl_t lvl;
        lvl = '0;
        for (int b = 0; b < IDX_WIDTH; b++) begin
            if (i[b]) lvl = LVL_WIDTH'(b);
        end
        return lvl;
    endfunction

endpackage

// ----- src/bhpq_ram.sv -----
// ============================================================================
// bhpq_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module bhpq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bhpq_cell.sv -----
// ============================================================================
// bhpq_cell
// One heap level: takes a sift token from a neighbor, reads its own level,
// compares, writes the held pair back to the neighbor level and passes on.
// ============================================================================
module bhpq_cell import bhpq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  heap_mode,
    input  cnt_t  count,
    input  tok_t  tok_in,
    input  pair_t rdata,
    output rreq_t rd_req,
    output wreq_t wr_own,
    output wreq_t wr_nb_up,
    output wreq_t wr_nb_dn,
    output tok_t  tok_out,
    output logic  done
);

    tok_t tok_reg;
    logic busy_reg;
    logic cmp_reg;
    logic act;

    logic [IDX_WIDTH:0] lw;
    logic [IDX_WIDTH:0] rw;
    logic [IDX_WIDTH:0] cnt_x;
    logic [IDX_WIDTH:0] best2;
    data_t              x;
    data_t              lv;
    data_t              rv;
    data_t              cv;
    data_t              pv;
    logic               l_ok;
    logic               r_ok;
    logic               move;
    logic               leaf;
    logic               swap;
    logic               at_root;
    idx_t               best;
    idx_t               q;
    pair_t              nb_pair;
    pair_t              own_pair;

    // token capture and read/compare phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cmp_reg  <= 1'b0;
        end else if (tok_in.valid) begin
            busy_reg <= 1'b1;
            cmp_reg  <= 1'b0;
        end else if (busy_reg && !cmp_reg) begin
            cmp_reg  <= 1'b1;
        end else begin
            busy_reg <= 1'b0;
            cmp_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in.valid) begin
            tok_reg <= tok_in;
        end
    end

    assign act = busy_reg && cmp_reg;

    // read the parent pair going up, the children pair going down
    always_comb begin
        rd_req.en  = busy_reg && !cmp_reg;
        rd_req.idx = tok_reg.up ? (tok_reg.idx >> 1) : idx_t'({tok_reg.idx, 1'b0});
    end

    // compare and steer
    always_comb begin
        x     = tok_reg.val;
        lv    = data_t'(rdata[0]);
        rv    = data_t'(rdata[1]);
        cnt_x = (IDX_WIDTH + 1)'(count);

        // sift down: pick the child that beats x, left wins ties
        lw    = {tok_reg.idx, 1'b0};
        rw    = {tok_reg.idx, 1'b1};
        l_ok  = (lw <= cnt_x) && ranks_above(heap_mode, lv, x);
        r_ok  = (rw <= cnt_x) && ranks_above(heap_mode, rv, l_ok ? lv : x);
        move  = l_ok || r_ok;
        best  = r_ok ? rw[IDX_WIDTH-1:0] : lw[IDX_WIDTH-1:0];
        cv    = r_ok ? rv : lv;
        best2 = {best, 1'b0};
        leaf  = best2 > cnt_x;

        // sift up: compare x against its parent
        q       = tok_reg.idx >> 1;
        pv      = data_t'(rdata[q[0]]);
        swap    = ranks_above(heap_mode, x, pv);
        at_root = (q == idx_t'(1));

        nb_pair  = tok_reg.held;
        own_pair = rdata;
        wr_own   = '0;
        wr_nb_up = '0;
        wr_nb_dn = '0;
        tok_out  = '0;
        done     = 1'b0;

        if (act) begin
            if (tok_reg.up) begin
                nb_pair[tok_reg.idx[0]] = swap ? pv : x;
                wr_nb_up.en   = 1'b1;
                wr_nb_up.idx  = tok_reg.idx;
                wr_nb_up.data = nb_pair;
                own_pair[1]   = x;
                wr_own.en     = swap && at_root;
                wr_own.idx    = q;
                wr_own.data   = own_pair;
                tok_out.valid = swap && !at_root;
                tok_out.up    = 1'b1;
                tok_out.idx   = q;
                tok_out.val   = x;
                tok_out.held  = rdata;
                done          = !swap || at_root;
            end else begin
                nb_pair[tok_reg.idx[0]] = move ? cv : x;
                wr_nb_dn.en   = 1'b1;
                wr_nb_dn.idx  = tok_reg.idx;
                wr_nb_dn.data = nb_pair;
                own_pair[best[0]] = x;
                wr_own.en     = move && leaf;
                wr_own.idx    = best;
                wr_own.data   = own_pair;
                tok_out.valid = move && !leaf;
                tok_out.up    = 1'b0;
                tok_out.idx   = best;
                tok_out.val   = x;
                tok_out.held  = rdata;
                done          = !move || leaf;
            end
        end
    end

endmodule

// ----- src/binary_heap_priority_queue.sv -----
// ============================================================================
// binary_heap_priority_queue
// Min or max binary heap of signed values built as a chain of level cells,
// each cell owning the memory of one heap level.
// ============================================================================
// Sequencing: an insert into an empty heap, a full insert, an empty pop or a pop
//   of the last entry goes from input transfer straight to the result; any other
//   item first fetches a pair, then walks the levels in a sift.
// Throughput: one item at a time; each level costs a registered memory read
//   and a compare/write in its cell, so the level walk and any output stall set the rate.
// Reset: clears the entry count and selects min order; no clearing pass.
module binary_heap_priority_queue import bhpq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // value[31:0]
    input  logic [0:0]             s_tuser,   // cmd[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [MDATA_WIDTH-1:0] m_tdata,   // popped_value[31:0], root_value[63:32],
                                              // root_valid[64], entry_count[75:65], zero pad
    output logic [1:0]             m_tuser    // status[1:0]
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_SIFT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                  state_reg;
    cnt_t                    count_reg;
    logic                    heap_mode_reg;
    data_t                   root_reg;
    logic                    cmd_reg;
    data_t                   val_reg;
    idx_t                    idx_reg;
    lvl_t                    lvl_reg;
    logic [VALUE_WIDTH-1:0]  popped_reg;
    status_t                 status_reg;
    logic                    m_tvalid_reg;
    logic [MDATA_WIDTH-1:0]  m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    s_accept;
    logic                    in_cmd;
    data_t                   in_val;
    logic                    is_full;
    logic                    is_empty;
    rreq_t                   top_rd;
    lvl_t                    top_rd_lvl;
    wreq_t                   top_wr;
    pair_t                   top_pair;
    pair_t                   fetch_pair;
    tok_t                    launch_tok;
    lvl_t                    launch_lvl;
    logic                    sift_done;
    logic [VALUE_WIDTH-1:0]  root_field;

    rreq_t                   cell_rd    [NUM_LEVELS];
    wreq_t                   cell_own   [NUM_LEVELS];
    tok_t                    cell_tok_in[NUM_LEVELS];
    pair_t                   ram_rdata  [NUM_LEVELS];
    wreq_t                   ram_wr     [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]   cell_done;
    // neighbor outputs padded by one empty slot at each end
    tok_t                    tok_from   [NUM_LEVELS+2];
    wreq_t                   up_from    [NUM_LEVELS+2];
    wreq_t                   dn_from    [NUM_LEVELS+2];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = s_tuser[0];
    assign in_val   = data_t'(signed'(s_tdata));
    assign is_full  = (count_reg == cnt_t'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // start-of-item memory access: new slot's pair for insert, last entry for pop
    always_comb begin
        top_rd.en  = s_accept && ((in_cmd == CMD_INSERT && !is_full && !is_empty) ||
                                  (in_cmd == CMD_POP && count_reg > cnt_t'(1)));
        top_rd.idx = (in_cmd == CMD_INSERT) ? idx_t'(count_reg + 1'b1) : idx_t'(count_reg);
        top_rd_lvl = level_of(top_rd.idx);
        top_pair    = '0;
        top_pair[1] = in_val;
        top_wr.en   = s_accept && (in_cmd == CMD_INSERT) && is_empty;
        top_wr.idx  = idx_t'(1);
        top_wr.data = top_pair;
    end

    // launch the sift token once the fetched pair is back
    always_comb begin
        fetch_pair = ram_rdata[lvl_reg];
        launch_tok = '0;
        launch_lvl = lvl_t'(1);
        if (state_reg == S_FETCH) begin
            launch_tok.valid = 1'b1;
            launch_tok.val   = val_reg;
            if (cmd_reg == CMD_INSERT) begin
                launch_tok.up   = 1'b1;
                launch_tok.idx  = idx_reg;
                launch_tok.held = fetch_pair;
                launch_lvl      = lvl_reg - 1'b1;
            end else begin
                launch_tok.up   = 1'b0;
                launch_tok.idx  = idx_t'(1);
                launch_tok.val  = data_t'(fetch_pair[idx_reg[0]]);
                launch_tok.held = '0;
                launch_lvl      = lvl_t'(1);
            end
        end
    end

    assign tok_from[0]            = '0;
    assign tok_from[NUM_LEVELS+1] = '0;
    assign up_from[0]             = '0;
    assign up_from[NUM_LEVELS+1]  = '0;
    assign dn_from[0]             = '0;
    assign dn_from[NUM_LEVELS+1]  = '0;

    // chain of level cells, each with its own level memory
    for (genvar j = 0; j < NUM_LEVELS; j++) begin : g_level
        localparam int DEPTH = level_depth(j);
        localparam int AW    = ram_addr_width(DEPTH);
        localparam int MASK  = (j > 0) ? ((1 << (j - 1)) - 1) : 0;

        logic          rd_sel;
        idx_t          ridx;
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;

        // token in from the launch point or a neighbor
        always_comb begin
            if (launch_tok.valid && launch_lvl == lvl_t'(j)) begin
                cell_tok_in[j] = launch_tok;
            end else if (tok_from[j+2].valid && tok_from[j+2].up) begin
                cell_tok_in[j] = tok_from[j+2];
            end else if (tok_from[j].valid && !tok_from[j].up) begin
                cell_tok_in[j] = tok_from[j];
            end else begin
                cell_tok_in[j] = '0;
            end
        end

        // write port: own finish, neighbor write-back, or direct root store
        always_comb begin
            if (cell_own[j].en) begin
                ram_wr[j] = cell_own[j];
            end else if (up_from[j].en) begin
                ram_wr[j] = up_from[j];
            end else if (dn_from[j+2].en) begin
                ram_wr[j] = dn_from[j+2];
            end else if (j == 0 && top_wr.en) begin
                ram_wr[j] = top_wr;
            end else begin
                ram_wr[j] = '0;
            end
        end

        assign rd_sel = top_rd.en && (top_rd_lvl == lvl_t'(j));
        assign ridx   = rd_sel ? top_rd.idx : cell_rd[j].idx;
        assign raddr  = AW'((ridx >> 1) & idx_t'(MASK));
        assign waddr  = AW'((ram_wr[j].idx >> 1) & idx_t'(MASK));

        bhpq_ram #(
            .WIDTH (2 * DATA_WIDTH),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_wr[j].en),
            .waddr (waddr),
            .wdata (ram_wr[j].data),
            .re    (rd_sel || cell_rd[j].en),
            .raddr (raddr),
            .rdata (ram_rdata[j])
        );

        bhpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .heap_mode (heap_mode_reg),
            .count     (count_reg),
            .tok_in    (cell_tok_in[j]),
            .rdata     (ram_rdata[j]),
            .rd_req    (cell_rd[j]),
            .wr_own    (cell_own[j]),
            .wr_nb_up  (up_from[j+1]),
            .wr_nb_dn  (dn_from[j+1]),
            .tok_out   (tok_from[j+1]),
            .done      (cell_done[j])
        );
    end

    assign sift_done = |cell_done;

    // root shadow follows every store to the top level
    always_ff @(posedge aclk) begin
        if (ram_wr[0].en) begin
            root_reg <= data_t'(ram_wr[0].data[1]);
        end
    end

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            heap_mode_reg <= cfg_wr_data;
        end
    end

    // item sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (in_cmd == CMD_INSERT) begin
                            if (is_full) begin
                                state_reg <= S_DONE;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                                state_reg <= is_empty ? S_DONE : S_FETCH;
                            end
                        end else begin
                            if (is_empty) begin
                                state_reg <= S_DONE;
                            end else begin
                                count_reg <= count_reg - 1'b1;
                                state_reg <= (count_reg == cnt_t'(1)) ? S_DONE : S_FETCH;
                            end
                        end
                    end
                end
                S_FETCH: begin
                    state_reg <= S_SIFT;
                end
                S_SIFT: begin
                    if (sift_done) state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // per-item payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= in_cmd;
            val_reg    <= in_val;
            idx_reg    <= top_rd.idx;
            lvl_reg    <= top_rd_lvl;
            popped_reg <= '0;
            status_reg <= STATUS_OK;
            if (in_cmd == CMD_INSERT) begin
                if (is_full) status_reg <= STATUS_FULL;
            end else begin
                if (is_empty) begin
                    status_reg <= STATUS_EMPTY;
                end else begin
                    popped_reg <= VALUE_WIDTH'(root_reg);
                end
            end
        end
    end

    assign root_field = is_empty ? '0 : VALUE_WIDTH'(root_reg);

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {4'b0000, COUNT_WIDTH'(count_reg), !is_empty, root_field,
                            popped_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // at most one cell finishes a sift at a time
    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_done))
        else $error("more than one cell finished a sift");

    // cells only finish while the sequencer waits for a sift
    a_done_in_sift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SIFT) |-> (cell_done == '0))
        else $error("cell finished outside a sift");

    // entry count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count above capacity");

    // a pop on a non-empty heap removes exactly one entry
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_POP && count_reg != '0)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement the entry count");

endmodule

// ----- tb/sv/binary_heap_priority_queue_tb.sv -----
// ============================================================================
// binary_heap_priority_queue_tb
// Self-checking bench for the binary heap priority queue. Insert and pop
// commands are streamed in under several idle and stall patterns while a
// behavioral heap in the bench predicts every result (popped value, root,
// entry count, status). Covers both heap orders, ties, value extremes, pops
// on an empty heap, inserts on a full heap and order changes with entries
// stored.
// ============================================================================
module binary_heap_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bhpq_pkg::*;

    localparam int SETTLE_CYCLES = 2 * NUM_LEVELS + 4;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int MIX_ITEMS     = 60;
    localparam int DRAIN_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 300;

    localparam data_t VAL_MAX = data_t'(32'h7FFF_FFFF);
    localparam data_t VAL_MIN = data_t'(32'h8000_0000);

    localparam logic ORDER_MIN = 1'b1;
    localparam logic ORDER_MAX = 1'b0;

    typedef struct {
        data_t   popped;
        data_t   root;
        logic    root_valid;
        cnt_t    count;
        status_t status;
    } heap_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_wr_data = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_WIDTH-1:0] s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MDATA_WIDTH-1:0] m_tdata;
    logic [1:0]             m_tuser;

    // behavioral heap and its order
    data_t model_heap [1:CAPACITY];
    int    model_count;
    logic  model_order;

    heap_result_t pending_results [$];
    heap_result_t want;

    int send_idle_pct;
    int recv_stall_pct;
    int ready_hold;
    int error_count;
    int cycle_count;

    binary_heap_priority_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // true if a sits above b under the current order
    function automatic bit outranks(input data_t a, input data_t b);
        return model_order ? (a < b) : (a > b);
    endfunction

    // apply one command to the behavioral heap and return its result
    function automatic heap_result_t apply_heap_op(input logic cmd, input data_t value);
        heap_result_t res;
        int           pos;
        int           lft;
        int           best;
        data_t        tmp;
        res.popped = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            if (model_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                model_count++;
                pos = model_count;
                model_heap[pos] = value;
                // sift up on strict order only
                while (pos > 1 && outranks(model_heap[pos], model_heap[pos / 2])) begin
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[pos / 2];
                    model_heap[pos / 2] = tmp;
                    pos = pos / 2;
                end
            end
        end else if (model_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.popped = model_heap[1];
            model_heap[1] = model_heap[model_count];
            model_count--;
            pos = 1;
            // sift down, left child wins unless the right one strictly beats it
            forever begin
                lft = 2 * pos;
                best = pos;
                if (lft <= model_count && outranks(model_heap[lft], model_heap[best]))
                    best = lft;
                if (lft + 1 <= model_count && outranks(model_heap[lft + 1], model_heap[best]))
                    best = lft + 1;
                if (best == pos)
                    break;
                tmp = model_heap[pos];
                model_heap[pos] = model_heap[best];
                model_heap[best] = tmp;
                pos = best;
            end
        end
        res.root       = (model_count != 0) ? model_heap[1] : '0;
        res.root_valid = (model_count != 0);
        res.count      = cnt_t'(model_count);
        return res;
    endfunction

    // mostly full-range values, with small values for ties and the extremes
    function automatic data_t rand_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return data_t'($urandom);
            5, 6:          return data_t'($urandom_range(6)) - 3;
            7:             return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default:       return data_t'($urandom_range(40)) - 20;
        endcase
    endfunction

    // offer one command, optionally after idle cycles, and predict it on transfer
    task automatic send_item(input logic cmd, input data_t value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_heap_op(cmd, value));
    endtask

    // stop offering and wait until the block has gone quiet
    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // heap order register, written only while idle
    task automatic write_order(input logic order);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        model_order = order;
    endtask

    // empty pops, value extremes, ties and min order
    task automatic test_empty_and_extremes();
        send_item(CMD_POP, rand_value());
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 1);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, 0);
        repeat (7) send_item(CMD_POP, rand_value());
        send_item(CMD_POP, VAL_MAX);
    endtask

    // max order, then a switch back to min order with entries stored
    task automatic test_max_order_and_mode_flip();
        write_order(ORDER_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 5);
        send_item(CMD_INSERT, 5);
        repeat (2) send_item(CMD_POP, rand_value());
        write_order(ORDER_MIN);
        repeat (3) send_item(CMD_POP, rand_value());
    endtask

    // random commands, insert-heavy then pop-heavy, under one idle pattern
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic order);
        int ins_pct;
        write_order(order);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < MIX_ITEMS; i++) begin
            ins_pct = (i < MIX_ITEMS / 2) ? 70 : 30;
            send_item(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_POP, rand_value());
        end
    endtask

    // fill to capacity behind a long output stall, then inserts on a full heap
    task automatic test_full_heap_backpressure();
        write_order(ORDER_MIN);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold     = HOLD_CYCLES;
        while (model_count < CAPACITY)
            send_item(($urandom_range(99) < 94) ? CMD_INSERT : CMD_POP, rand_value());
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_POP, rand_value());
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, rand_value());
        send_item(CMD_INSERT, rand_value());
    endtask

    // flip to max order with a full heap and pop through deep sifts
    task automatic test_drain_other_order();
        write_order(ORDER_MAX);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        for (int i = 0; i < DRAIN_ITEMS; i++)
            send_item(($urandom_range(99) < 85) ? CMD_POP : CMD_INSERT, rand_value());
    endtask

    // output ready with random stalls, or held low for a counted stretch
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h / %h",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("popped_value", want.popped, m_tdata[31:0]);
                check_field("root_value", want.root, m_tdata[63:32]);
                check_field("root_valid", 32'(want.root_valid), 32'(m_tdata[64]));
                check_field("entry_count", 32'(want.count), 32'(m_tdata[75:65]));
                check_field("status", 32'(want.status), 32'(m_tuser));
            end
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_heap_priority_queue_tb failed");
            $finish;
        end
    end

    initial begin
        model_count    = 0;
        model_order    = ORDER_MIN;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold     = 0;
        error_count    = 0;
        cycle_count    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_extremes();
        test_max_order_and_mode_flip();
        test_random_traffic(0, 0, ORDER_MIN);
        test_random_traffic(69, 0, ORDER_MAX);
        test_random_traffic(0, 69, ORDER_MIN);
        test_random_traffic(8, 8, ORDER_MAX);
        test_full_heap_backpressure();
        test_drain_other_order();
        wait_all_results();

        if (error_count == 0) begin
            $display("binary_heap_priority_queue_tb passed");
        end else begin
            $display("binary_heap_priority_queue_tb failed");
        end
        $finish;
    end

endmodule
